// ===== rtl/vrps_pkg.sv =====
// Shared types and constants for the video register port.
`timescale 1ns / 1ps

package vrps_pkg;

    localparam int NT_BYTES  = 2048;
    localparam int NT_AW     = $clog2(NT_BYTES);
    localparam int SPR_BYTES = 256;
    localparam int SPR_AW    = $clog2(SPR_BYTES);
    localparam int PAL_BYTES = 32;
    localparam int PAL_AW    = $clog2(PAL_BYTES);

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_VB_SET = 2'd2,
        ACT_VB_CLR = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        MIR_VERT = 2'd0,
        MIR_HORZ = 2'd1,
        MIR_LOW  = 2'd2,
        MIR_HIGH = 2'd3
    } t_mirror;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_STATUS,
        RD_SPRITE,
        RD_DATA
    } t_rd_kind;

    typedef enum logic [1:0] {
        SRC_CART,
        SRC_NT,
        SRC_PAL
    } t_src;

    typedef struct packed {
        t_action    action;
        logic [2:0] reg_index;
        logic [7:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        nmi_request;
        logic [15:0] vram_address;
        logic [14:0] temp_address;
        logic [2:0]  fine_x_scroll;
    } t_out_word;

    // Item waiting on its memory read data.
    typedef struct packed {
        t_rd_kind    kind;
        t_src        src;
        logic        pal_page;
        logic        vblank;
        logic        nmi;
        logic [15:0] vram;
        logic [14:0] temp;
        logic [2:0]  fine;
    } t_s2;

endpackage

// ===== rtl/vrps_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module vrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/video_register_port_scroll_vram.sv =====
// Top level of the video register port: scroll registers, data port and memories.
`timescale 1ns / 1ps

// CPU-facing register port of a tile video chip. One word per cycle is taken
// while the result side keeps up; each word yields one result word (the accept
// edge issues the memory read, and the result register loads when stage 2
// advances). Register state updates at the accept edge; only the read buffer
// waits for the registered memory data. After reset a clearing pass zeroes
// nametable, palette and sprite memory, and no input word is taken during it
// (the mirror register can be written at any time).

module video_register_port_scroll_vram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  vrps_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vrps_pkg::t_out_word o_out_word
);

    function automatic logic [vrps_pkg::NT_AW-1:0] nt_index(
        input logic [15:0] a,
        input vrps_pkg::t_mirror m
    );
        logic [11:0] r;
        case (m)
            vrps_pkg::MIR_VERT: r = {1'b0, a[10], a[9:0]};
            vrps_pkg::MIR_HORZ: r = {1'b0, a[11], a[9:0]};
            vrps_pkg::MIR_LOW:  r = {2'b00, a[9:0]};
            default:            r = {2'b01, a[9:0]};
        endcase
        return r[vrps_pkg::NT_AW-1:0];
    endfunction

    function automatic logic [vrps_pkg::PAL_AW-1:0] pal_index(input logic [15:0] a);
        logic [4:0] i;
        i = a[4:0];
        // backdrop mirrors of the sprite palettes
        if (i[1:0] == 2'b00) begin
            i[4] = 1'b0;
        end
        return i;
    endfunction

    // architectural state
    vrps_pkg::t_mirror          r_mirror;
    logic                       r_ctrl_inc;
    logic [7:0]                 r_ptr,     n_ptr;
    logic [7:0]                 r_rbuf;
    logic [15:0]                r_cur,     n_cur;
    logic [14:0]                r_temp,    n_temp;
    logic [2:0]                 r_fine,    n_fine;
    logic                       r_toggle,  n_toggle;
    logic                       r_nmi_en,  n_nmi_en;
    logic                       r_vblank,  n_vblank;
    logic                       n_ctrl_inc;

    // clearing pass
    logic                       r_clr_active;
    logic [vrps_pkg::NT_AW-1:0] r_clr_addr;

    // pipeline
    logic                       r_s2_valid;
    vrps_pkg::t_s2              r_s2, n_s2;
    logic                       r_out_valid;
    vrps_pkg::t_out_word        r_out, n_out;

    logic                       s2_adv;
    logic                       in_acc;
    vrps_pkg::t_reg             in_reg;
    vrps_pkg::t_src             cur_src;
    logic [15:0]                cur_next;

    // memory ports
    logic                        nt_we, nt_re, pal_we, pal_re, spr_we, spr_re;
    logic [vrps_pkg::NT_AW-1:0]  nt_waddr, nt_raddr;
    logic [vrps_pkg::PAL_AW-1:0] pal_waddr, pal_raddr;
    logic [vrps_pkg::SPR_AW-1:0] spr_waddr;
    logic [7:0]                  mem_wdata;
    logic [7:0]                  nt_rdata, pal_rdata, spr_rdata;
    logic [7:0]                  space_data;

    assign o_cfg_ready = 1'b1;

    assign s2_adv     = r_s2_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_active || (r_s2_valid && !s2_adv);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_reg     = vrps_pkg::t_reg'(i_in_word.reg_index);

    assign cur_next = r_cur + (r_ctrl_inc ? 16'd32 : 16'd1);

    always_comb begin
        if (r_cur[15:13] == 3'b000) begin
            cur_src = vrps_pkg::SRC_CART;
        end else if (r_cur < 16'h3F00) begin
            cur_src = vrps_pkg::SRC_NT;
        end else begin
            cur_src = vrps_pkg::SRC_PAL;
        end
    end

    // register next state, memory requests and the stage-2 record
    always_comb begin
        n_ptr      = r_ptr;
        n_cur      = r_cur;
        n_temp     = r_temp;
        n_fine     = r_fine;
        n_toggle   = r_toggle;
        n_nmi_en   = r_nmi_en;
        n_vblank   = r_vblank;
        n_ctrl_inc = r_ctrl_inc;
        n_s2.kind     = vrps_pkg::RD_NONE;
        n_s2.src      = cur_src;
        n_s2.pal_page = (r_cur[13:8] == 6'h3F);
        n_s2.vblank   = r_vblank;
        n_s2.nmi      = 1'b0;
        spr_re = 1'b0;
        nt_re  = 1'b0;
        pal_re = 1'b0;
        spr_we = 1'b0;
        nt_we  = 1'b0;
        pal_we = 1'b0;
        if (in_acc) begin
            case (i_in_word.action)
                vrps_pkg::ACT_READ: begin
                    case (in_reg)
                        vrps_pkg::REG_STATUS: begin
                            n_s2.kind = vrps_pkg::RD_STATUS;
                            n_vblank  = 1'b0;
                            n_toggle  = 1'b0;
                            n_nmi_en  = 1'b0;
                        end
                        vrps_pkg::REG_OAM_DATA: begin
                            n_s2.kind = vrps_pkg::RD_SPRITE;
                            spr_re    = 1'b1;
                        end
                        vrps_pkg::REG_DATA: begin
                            n_s2.kind = vrps_pkg::RD_DATA;
                            nt_re     = (cur_src == vrps_pkg::SRC_NT);
                            pal_re    = (cur_src == vrps_pkg::SRC_PAL);
                            n_cur     = cur_next;
                        end
                        default: begin
                        end
                    endcase
                end
                vrps_pkg::ACT_WRITE: begin
                    case (in_reg)
                        vrps_pkg::REG_CTRL: begin
                            n_ctrl_inc    = i_in_word.write_data[2];
                            n_temp[11:10] = i_in_word.write_data[1:0];
                            n_nmi_en      = i_in_word.write_data[7];
                        end
                        vrps_pkg::REG_OAM_ADDR: begin
                            n_ptr = i_in_word.write_data;
                        end
                        vrps_pkg::REG_OAM_DATA: begin
                            spr_we = 1'b1;
                            n_ptr  = r_ptr + 8'd1;
                        end
                        vrps_pkg::REG_SCROLL: begin
                            if (!r_toggle) begin
                                n_temp[4:0] = i_in_word.write_data[7:3];
                                n_fine      = i_in_word.write_data[2:0];
                                n_toggle    = 1'b1;
                            end else begin
                                n_temp[14:12] = i_in_word.write_data[2:0];
                                n_temp[9:5]   = i_in_word.write_data[7:3];
                                n_toggle      = 1'b0;
                            end
                        end
                        vrps_pkg::REG_ADDR: begin
                            if (!r_toggle) begin
                                n_temp[14]   = 1'b0;
                                n_temp[13:8] = i_in_word.write_data[5:0];
                                n_toggle     = 1'b1;
                            end else begin
                                n_temp[7:0] = i_in_word.write_data;
                                n_cur       = {1'b0, r_temp[14:8], i_in_word.write_data};
                                n_toggle    = 1'b0;
                            end
                        end
                        vrps_pkg::REG_DATA: begin
                            nt_we  = (cur_src == vrps_pkg::SRC_NT);
                            pal_we = (cur_src == vrps_pkg::SRC_PAL);
                            n_cur  = cur_next;
                        end
                        default: begin
                        end
                    endcase
                end
                vrps_pkg::ACT_VB_SET: begin
                    n_vblank = 1'b1;
                    n_s2.nmi = r_nmi_en;
                end
                default: begin
                    n_vblank = 1'b0;
                end
            endcase
        end
        n_s2.vram = n_cur;
        n_s2.temp = n_temp;
        n_s2.fine = n_fine;
        // the clearing pass owns the write ports
        if (r_clr_active) begin
            nt_we  = 1'b1;
            pal_we = 1'b1;
            spr_we = 1'b1;
        end
    end

    assign mem_wdata = r_clr_active ? 8'h00 : i_in_word.write_data;
    assign nt_waddr  = r_clr_active ? r_clr_addr
                                    : nt_index(r_cur, r_mirror);
    assign pal_waddr = r_clr_active ? r_clr_addr[vrps_pkg::PAL_AW-1:0] : pal_index(r_cur);
    assign spr_waddr = r_clr_active ? r_clr_addr[vrps_pkg::SPR_AW-1:0] : r_ptr;
    assign nt_raddr  = nt_index(r_cur, r_mirror);
    assign pal_raddr = pal_index(r_cur);

    vrps_ram #(.WIDTH(8), .DEPTH(vrps_pkg::NT_BYTES)) u_nt_ram (
        .i_clk   (i_clk),
        .i_we    (nt_we),
        .i_waddr (nt_waddr),
        .i_wdata (mem_wdata),
        .i_re    (nt_re),
        .i_raddr (nt_raddr),
        .o_rdata (nt_rdata)
    );

    vrps_ram #(.WIDTH(8), .DEPTH(vrps_pkg::PAL_BYTES)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (mem_wdata),
        .i_re    (pal_re),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    vrps_ram #(.WIDTH(8), .DEPTH(vrps_pkg::SPR_BYTES)) u_spr_ram (
        .i_clk   (i_clk),
        .i_we    (spr_we),
        .i_waddr (spr_waddr),
        .i_wdata (mem_wdata),
        .i_re    (spr_re),
        .i_raddr (r_ptr),
        .o_rdata (spr_rdata)
    );

    // stage 2: memory data is valid, build the result word
    always_comb begin
        case (r_s2.src)
            vrps_pkg::SRC_NT:  space_data = nt_rdata;
            vrps_pkg::SRC_PAL: space_data = pal_rdata;
            default:           space_data = 8'h00;
        endcase
        n_out.nmi_request   = r_s2.nmi;
        n_out.vram_address  = r_s2.vram;
        n_out.temp_address  = r_s2.temp;
        n_out.fine_x_scroll = r_s2.fine;
        case (r_s2.kind)
            vrps_pkg::RD_STATUS: n_out.read_data = {r_s2.vblank, 2'b00, r_rbuf[4:0]};
            vrps_pkg::RD_SPRITE: n_out.read_data = spr_rdata;
            vrps_pkg::RD_DATA:   n_out.read_data = r_s2.pal_page ? space_data : r_rbuf;
            default:             n_out.read_data = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror     <= vrps_pkg::MIR_VERT;
            r_ctrl_inc   <= 1'b0;
            r_ptr        <= '0;
            r_rbuf       <= '0;
            r_cur        <= '0;
            r_temp       <= '0;
            r_fine       <= '0;
            r_toggle     <= 1'b0;
            r_nmi_en     <= 1'b0;
            r_vblank     <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mirror <= vrps_pkg::t_mirror'(i_cfg_data);
            end
            r_ctrl_inc <= n_ctrl_inc;
            r_ptr      <= n_ptr;
            r_cur      <= n_cur;
            r_temp     <= n_temp;
            r_fine     <= n_fine;
            r_toggle   <= n_toggle;
            r_nmi_en   <= n_nmi_en;
            r_vblank   <= n_vblank;
            if (s2_adv && r_s2.kind == vrps_pkg::RD_DATA) begin
                r_rbuf <= space_data;
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == vrps_pkg::NT_AW'(vrps_pkg::NT_BYTES - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (in_acc) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s2 <= n_s2;
        end
        if (s2_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef NO_ASSERTIONS
    // a stuck stage 2 keeps its record
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s2_adv) |=> (r_s2_valid && $stable(r_s2)))
        else $error("stage 2 record changed while stalled");

    // no read may disturb the registered memory data of a stuck item
    a_no_read_when_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s2_adv) |-> (!spr_re && !nt_re && !pal_re))
        else $error("memory read issued while stage 2 is stalled");

    // status read resets the write toggle and the vblank flag
    a_status_clears_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.action == vrps_pkg::ACT_READ
            && in_reg == vrps_pkg::REG_STATUS) |=> (!r_toggle && !r_vblank))
        else $error("status read left toggle or vblank set");

    // nothing enters before memory clearing is complete
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (!in_acc && !r_s2_valid))
        else $error("word accepted during clearing pass");
`endif

endmodule
